@@ src/tts_pkg.sv @@
// ----------------------------------------------------------------------------
// tts_pkg
// Types shared by the triangle trapezoid split pipeline stages.
// ----------------------------------------------------------------------------
package tts_pkg;

    localparam int CoordW = 20;
    localparam int DiffW  = CoordW + 1;
    localparam int ProdW  = 2 * DiffW;
    localparam int InW    = 6 * CoordW;
    localparam int OutW   = 48;

    typedef logic signed [CoordW-1:0] t_coord;
    typedef logic signed [DiffW-1:0]  t_diff;
    typedef logic signed [ProdW-1:0]  t_prod;
    typedef logic [1:0]               t_idx;

    // kind of triangle after classification
    typedef enum logic [1:0] {
        K_EMPTY,
        K_FLAT_BOT,
        K_FLAT_TOP,
        K_SPLIT
    } t_kind;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_idx   idx;
    } t_vtx;

    // vertices in ascending y order
    typedef struct packed {
        t_vtx v1;
        t_vtx v2;
        t_vtx v3;
    } t_sorted;

    typedef struct packed {
        t_kind  kind;
        t_coord y1;
        t_coord y2;
        t_coord y3;
        t_idx   i1;
        t_idx   i2;
        t_idx   i3;
    } t_tri;

    typedef struct packed {
        t_tri  shape;
        t_diff dx21;
        t_diff dy31;
        t_diff dx31;
        t_diff dy21;
    } t_cls;

    typedef struct packed {
        t_tri  shape;
        t_prod lhs;
        t_prod rhs;
    } t_prd;

    typedef struct packed {
        t_tri shape;
        logic split_left;
    } t_rec;

endpackage

@@ src/tts_sort.sv @@
// ----------------------------------------------------------------------------
// tts_sort
// Unpacks the three vertices and orders them by y with three compare-swaps.
// ----------------------------------------------------------------------------
module tts_sort
    import tts_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [InW-1:0]   i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output t_sorted          o_data
);

    logic    r_valid;
    t_sorted r_data;
    t_sorted n_data;
    t_vtx    va, vb, vc;
    t_vtx    s1a, s1b, s2a, s2c, s3b, s3c;

    // vertex unpack, a in the lowest bits
    assign va = '{x: i_data[19:0],   y: i_data[39:20],   idx: 2'd0};
    assign vb = '{x: i_data[59:40],  y: i_data[79:60],   idx: 2'd1};
    assign vc = '{x: i_data[99:80],  y: i_data[119:100], idx: 2'd2};

    // strict-greater compare-swaps on (1,2), (1,3), (2,3)
    always_comb begin
        if (va.y > vb.y) begin
            s1a = vb;
            s1b = va;
        end else begin
            s1a = va;
            s1b = vb;
        end
        if (s1a.y > vc.y) begin
            s2a = vc;
            s2c = s1a;
        end else begin
            s2a = s1a;
            s2c = vc;
        end
        if (s1b.y > s2c.y) begin
            s3b = s2c;
            s3c = s1b;
        end else begin
            s3b = s1b;
            s3c = s2c;
        end
        n_data = '{v1: s2a, v2: s3b, v3: s3c};
    end

    // stage handshake
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ src/tts_classify.sv @@
// ----------------------------------------------------------------------------
// tts_classify
// Sorts out degenerate, flat bottom, flat top and general triangles and
// forms the edge differences for the split side test.
// ----------------------------------------------------------------------------
module tts_classify
    import tts_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_sorted i_data,
    output logic    o_valid,
    input  logic    i_ready,
    output t_cls    o_data
);

    logic r_valid;
    t_cls r_data;
    t_cls n_data;
    t_vtx p1, p2, p3;
    logic all_y_eq, all_x_eq;

    assign p1 = i_data.v1;
    assign p2 = i_data.v2;
    assign p3 = i_data.v3;

    assign all_y_eq = (p1.y == p2.y) && (p1.y == p3.y);
    assign all_x_eq = (p1.x == p2.x) && (p1.x == p3.x);

    // classification and flat-edge ordering by x
    always_comb begin
        n_data.shape.y1 = p1.y;
        n_data.shape.y2 = p2.y;
        n_data.shape.y3 = p3.y;
        n_data.shape.i1 = p1.idx;
        n_data.shape.i2 = p2.idx;
        n_data.shape.i3 = p3.idx;
        if (all_y_eq || all_x_eq) begin
            n_data.shape.kind = K_EMPTY;
        end else if (p1.y == p2.y) begin
            n_data.shape.kind = K_FLAT_BOT;
            if (p1.x > p2.x) begin
                n_data.shape.i1 = p2.idx;
                n_data.shape.i2 = p1.idx;
            end
        end else if (p2.y == p3.y) begin
            n_data.shape.kind = K_FLAT_TOP;
            if (p2.x > p3.x) begin
                n_data.shape.i2 = p3.idx;
                n_data.shape.i3 = p2.idx;
            end
        end else begin
            n_data.shape.kind = K_SPLIT;
        end
        n_data.dx21 = t_diff'(p2.x) - t_diff'(p1.x);
        n_data.dy31 = t_diff'(p3.y) - t_diff'(p1.y);
        n_data.dx31 = t_diff'(p3.x) - t_diff'(p1.x);
        n_data.dy21 = t_diff'(p2.y) - t_diff'(p1.y);
    end

    // stage handshake
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ src/tts_cross.sv @@
// ----------------------------------------------------------------------------
// tts_cross
// Exact split side test: two cross products in one stage, their compare in
// the next.
// ----------------------------------------------------------------------------
module tts_cross
    import tts_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_cls i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_rec o_data
);

    logic r_valid_p;
    t_prd r_prd;
    t_prd n_prd;
    logic r_valid_c;
    t_rec r_rec;
    t_rec n_rec;
    logic ready_c;

    // product stage
    always_comb begin
        n_prd.shape = i_data.shape;
        n_prd.lhs   = i_data.dx21 * i_data.dy31;
        n_prd.rhs   = i_data.dx31 * i_data.dy21;
    end

    assign ready_c = !r_valid_c || i_ready;
    assign o_ready = !r_valid_p || ready_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_p <= 1'b0;
        end else if (o_ready) begin
            r_valid_p <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_prd <= n_prd;
        end
    end

    // compare stage, left split when lhs <= rhs
    always_comb begin
        n_rec.shape      = r_prd.shape;
        n_rec.split_left = (r_prd.lhs <= r_prd.rhs);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_c <= 1'b0;
        end else if (ready_c) begin
            r_valid_c <= r_valid_p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_c && r_valid_p) begin
            r_rec <= n_rec;
        end
    end

    assign o_valid = r_valid_c;
    assign o_data  = r_rec;

endmodule

@@ src/tts_emit.sv @@
// ----------------------------------------------------------------------------
// tts_emit
// Output register that issues one or two trapezoid transactions per
// triangle.
// ----------------------------------------------------------------------------
module tts_emit
    import tts_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  t_rec            i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [OutW-1:0] o_data,
    output logic            o_user,
    output logic            o_last
);

    logic   r_valid;
    logic   r_beat;
    t_rec   r_rec;
    logic   n_beat;
    logic   final_beat;
    t_coord top_y, bot_y;
    t_idx   ls, le, rs, re;
    logic   empty_res;

    assign final_beat = (r_rec.shape.kind != K_SPLIT) || r_beat;
    assign o_ready    = !r_valid || (i_ready && final_beat);

    // beat counter
    always_comb begin
        n_beat = r_beat;
        if (o_ready) begin
            n_beat = 1'b0;
        end else if (i_ready) begin
            n_beat = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_beat  <= 1'b0;
        end else begin
            r_beat <= n_beat;
            if (o_ready) begin
                r_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_rec <= i_data;
        end
    end

    // result fields for the current beat
    always_comb begin
        empty_res = 1'b0;
        top_y     = r_rec.shape.y1;
        bot_y     = r_rec.shape.y3;
        ls        = r_rec.shape.i1;
        le        = r_rec.shape.i3;
        rs        = r_rec.shape.i2;
        re        = r_rec.shape.i3;
        unique case (r_rec.shape.kind)
            K_EMPTY: begin
                empty_res = 1'b1;
                top_y     = '0;
                bot_y     = '0;
                ls        = '0;
                le        = '0;
                rs        = '0;
                re        = '0;
            end
            K_FLAT_BOT: begin
                ls = r_rec.shape.i1;
                le = r_rec.shape.i3;
                rs = r_rec.shape.i2;
                re = r_rec.shape.i3;
            end
            K_FLAT_TOP: begin
                ls = r_rec.shape.i1;
                le = r_rec.shape.i2;
                rs = r_rec.shape.i1;
                re = r_rec.shape.i3;
            end
            K_SPLIT: begin
                if (!r_beat) begin
                    top_y = r_rec.shape.y1;
                    bot_y = r_rec.shape.y2;
                end else begin
                    top_y = r_rec.shape.y2;
                    bot_y = r_rec.shape.y3;
                end
                // long edge p1 to p3 is on the split's opposite side
                if (r_rec.split_left) begin
                    ls = r_beat ? r_rec.shape.i2 : r_rec.shape.i1;
                    le = r_beat ? r_rec.shape.i3 : r_rec.shape.i2;
                    rs = r_rec.shape.i1;
                    re = r_rec.shape.i3;
                end else begin
                    ls = r_rec.shape.i1;
                    le = r_rec.shape.i3;
                    rs = r_beat ? r_rec.shape.i2 : r_rec.shape.i1;
                    re = r_beat ? r_rec.shape.i3 : r_rec.shape.i2;
                end
            end
            default: begin
                empty_res = 1'b1;
            end
        endcase
    end

    assign o_valid = r_valid;
    assign o_data  = {re, rs, le, ls, bot_y, top_y};
    assign o_user  = empty_res;
    assign o_last  = final_beat;

endmodule

@@ src/triangle_trapezoid_split.sv @@
// Throughput: one triangle per cycle when it yields one trapezoid and the result
// side does not stall; a split triangle holds the emitter until its second
// trapezoid is taken, as the emitter has a single result channel.
// Reset: i_rst_n synchronous active low clears all stage valid bits and the
// beat counter; no clearing pass, input is taken in the first cycle after.
// ----------------------------------------------------------------------------
// triangle_trapezoid_split
// Sorts three vertices by y and splits the triangle into one or two trapezoids,
// or one empty result, in a sort, classify, multiply, compare, emit pipeline.
// ----------------------------------------------------------------------------
module triangle_trapezoid_split
    import tts_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    // tdata: ax, ay, bx, by_coord, cx, cy (20 bits each, from bit 0 up)
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic [InW-1:0]  s_axis_tdata,
    // tdata: top_y, bottom_y (20 bits), left_start, left_end,
    //        right_start, right_end (2 bits each), from bit 0 up
    // tuser: empty_res
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [OutW-1:0] m_axis_tdata,
    output logic            m_axis_tuser,
    output logic            m_axis_tlast
);

    logic    srt_valid, srt_ready;
    t_sorted srt_data;
    logic    cls_valid, cls_ready;
    t_cls    cls_data;
    logic    crs_valid, crs_ready;
    t_rec    crs_data;

    // sort stage
    tts_sort u_sort (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .o_valid (srt_valid),
        .i_ready (srt_ready),
        .o_data  (srt_data)
    );

    // classify stage
    tts_classify u_classify (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (srt_valid),
        .o_ready (srt_ready),
        .i_data  (srt_data),
        .o_valid (cls_valid),
        .i_ready (cls_ready),
        .o_data  (cls_data)
    );

    // cross product and compare stages
    tts_cross u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cls_valid),
        .o_ready (cls_ready),
        .i_data  (cls_data),
        .o_valid (crs_valid),
        .i_ready (crs_ready),
        .o_data  (crs_data)
    );

    // result emitter
    tts_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (crs_valid),
        .o_ready (crs_ready),
        .i_data  (crs_data),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_user  (m_axis_tuser),
        .o_last  (m_axis_tlast)
    );

endmodule

@@ src/tts_checker.sv @@
// ----------------------------------------------------------------------------
// tts_checker
// Port-level checks on the trapezoid result stream.
// ----------------------------------------------------------------------------
module tts_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    // a stalled result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // an empty result is alone and all zero
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == 48'd0))
        else $error("empty result not last or not zero");

    // a trapezoid runs downward in y
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |->
            $signed(m_axis_tdata[19:0]) <= $signed(m_axis_tdata[39:20]))
        else $error("top below bottom");

    // the second trapezoid follows the first at once
    a_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
        else $error("second trapezoid missing");

    // the second trapezoid starts where the first ended
    a_joint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tdata[19:0] == $past(m_axis_tdata[39:20]))
        else $error("split trapezoids do not meet");

endmodule

bind triangle_trapezoid_split tts_checker u_tts_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

@@ sim/triangle_trapezoid_split_tb.sv @@
// ----------------------------------------------------------------------------
// triangle_trapezoid_split_tb
// Self-checking bench for the trapezoid split. Triangles go in on the slave
// stream, and each accepted one is run through a local model of the y sort,
// the flat-edge and degenerate tests and the cross-multiplied split test.
// Every result transaction is checked field by field against the oldest
// trapezoid still owed. Both stream sides stall at random, with one calm
// stretch where neither side stalls.
// ----------------------------------------------------------------------------
module triangle_trapezoid_split_tb;
    import tts_pkg::*;

    localparam int CycleLimit = 200000;
    localparam int RandomTris = 1400;
    localparam int CoordMax   = 524287;
    localparam int CoordMin   = -524288;

    // one trapezoid as seen on the result stream
    typedef struct {
        logic   is_empty;
        t_coord top;
        t_coord bottom;
        t_idx   l_start;
        t_idx   l_end;
        t_idx   r_start;
        t_idx   r_end;
        logic   is_last;
    } t_trap;

    // owed trapezoids, filled as triangles are accepted
    class trapezoid_ledger;
        t_trap owed[$];
        int    mismatches;
        int    triangles;
        int    degenerate;
        int    flat;
        int    split;
        int    checked;

        function void owe(logic empty, t_coord top, t_coord bottom,
                          int ls, int le, int rs, int re, logic lst);
            t_trap t;
            t.is_empty = empty;
            t.top      = top;
            t.bottom   = bottom;
            t.l_start  = t_idx'(ls);
            t.l_end    = t_idx'(le);
            t.r_start  = t_idx'(rs);
            t.r_end    = t_idx'(re);
            t.is_last  = lst;
            owed.push_back(t);
        endfunction

        // sort by y, classify and split one accepted triangle
        function void note_triangle(logic [InW-1:0] word);
            t_coord  x[3];
            t_coord  y[3];
            int      p1;
            int      p2;
            int      p3;
            int      tmp;
            longint  lhs;
            longint  rhs;
            p1 = 0;
            p2 = 1;
            p3 = 2;
            for (int i = 0; i < 3; i++) begin
                x[i] = word[i*2*CoordW +: CoordW];
                y[i] = word[i*2*CoordW + CoordW +: CoordW];
            end
            triangles++;
            // strict compare-swaps on (1,2), (1,3), (2,3)
            if (y[p1] > y[p2]) begin
                tmp = p1; p1 = p2; p2 = tmp;
            end
            if (y[p1] > y[p3]) begin
                tmp = p1; p1 = p3; p3 = tmp;
            end
            if (y[p2] > y[p3]) begin
                tmp = p2; p2 = p3; p3 = tmp;
            end
            if ((y[p1] == y[p2] && y[p1] == y[p3]) ||
                (x[p1] == x[p2] && x[p1] == x[p3])) begin
                degenerate++;
                owe(1'b1, '0, '0, 0, 0, 0, 0, 1'b1);
            end else if (y[p1] == y[p2]) begin
                // flat bottom edge on top: order the pair by x
                flat++;
                if (x[p1] > x[p2]) begin
                    tmp = p1; p1 = p2; p2 = tmp;
                end
                owe(1'b0, y[p1], y[p3], p1, p3, p2, p3, 1'b1);
            end else if (y[p2] == y[p3]) begin
                flat++;
                if (x[p2] > x[p3]) begin
                    tmp = p2; p2 = p3; p3 = tmp;
                end
                owe(1'b0, y[p1], y[p3], p1, p2, p1, p3, 1'b1);
            end else begin
                split++;
                lhs = (longint'(x[p2]) - longint'(x[p1])) *
                      (longint'(y[p3]) - longint'(y[p1]));
                rhs = (longint'(x[p3]) - longint'(x[p1])) *
                      (longint'(y[p2]) - longint'(y[p1]));
                if (lhs <= rhs) begin
                    // middle vertex on the left
                    owe(1'b0, y[p1], y[p2], p1, p2, p1, p3, 1'b0);
                    owe(1'b0, y[p2], y[p3], p2, p3, p1, p3, 1'b1);
                end else begin
                    owe(1'b0, y[p1], y[p2], p1, p3, p1, p2, 1'b0);
                    owe(1'b0, y[p2], y[p3], p1, p3, p2, p3, 1'b1);
                end
            end
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_trapezoid(logic [OutW-1:0] data, logic user,
                                      logic lst);
            t_trap t;
            if (owed.size() == 0) begin
                $error("result transaction with no trapezoid owed");
                mismatches++;
                return;
            end
            t = owed.pop_front();
            checked++;
            compare_field("empty_res", t.is_empty, user);
            compare_field("top_y", longint'(t.top), longint'(t_coord'(data[19:0])));
            compare_field("bottom_y", longint'(t.bottom),
                          longint'(t_coord'(data[39:20])));
            compare_field("left_start", t.l_start, data[41:40]);
            compare_field("left_end", t.l_end, data[43:42]);
            compare_field("right_start", t.r_start, data[45:44]);
            compare_field("right_end", t.r_end, data[47:46]);
            compare_field("last", t.is_last, lst);
        endfunction
    endclass

    logic            i_clk;
    logic            i_rst_n;
    logic            s_axis_tvalid;
    logic            s_axis_tready;
    logic [InW-1:0]  s_axis_tdata;   // ax, ay, bx, by_coord, cx, cy from bit 0 up
    logic            m_axis_tvalid;
    logic            m_axis_tready;
    logic [OutW-1:0] m_axis_tdata;   // top_y, bottom_y, left/right start/end from bit 0 up
    logic            m_axis_tuser;   // empty_res
    logic            m_axis_tlast;

    trapezoid_ledger board;
    logic            steady;
    int              cycles;
    int              directed;

    triangle_trapezoid_split dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("triangle_trapezoid_split verification failed");
            $finish;
        end
    end

    // result side backpressure
    always @(negedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(99) >= 29);
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            board.check_trapezoid(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
    end

    // present one triangle and hold it until the transaction completes
    task automatic send_triangle(input int x0, input int y0, input int x1,
                                 input int y1, input int x2, input int y2);
        logic [InW-1:0] word;
        word = {t_coord'(y2), t_coord'(x2), t_coord'(y1), t_coord'(x1),
                t_coord'(y0), t_coord'(x0)};
        while (!steady && $urandom_range(99) < 29) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_triangle(word);
    endtask

    function automatic int spread(int r);
        return int'($urandom_range(2 * r)) - r;
    endfunction

    function automatic int pick_edge();
        case ($urandom_range(5))
            0: return CoordMin;
            1: return CoordMax;
            2: return 0;
            3: return -1;
            4: return 1;
            default: return int'($urandom);
        endcase
    endfunction

    // random triangles, weighted toward ties, flat edges and near-collinear
    task automatic send_random(input int n);
        int x[3];
        int y[3];
        int kind;
        int dx;
        int dy;
        int k;
        int m;
        int pa;
        int pb;
        for (int i = 0; i < n; i++) begin
            steady = (i >= 500 && i < 850);
            kind = $urandom_range(99);
            for (int j = 0; j < 3; j++) begin
                x[j] = spread(5000);
                y[j] = spread(5000);
            end
            if (kind < 25) begin
                // full range, every bit
                for (int j = 0; j < 3; j++) begin
                    x[j] = int'($urandom);
                    y[j] = int'($urandom);
                end
            end else if (kind < 45) begin
                // tiny grid, lots of equal coordinates
                for (int j = 0; j < 3; j++) begin
                    x[j] = spread(4);
                    y[j] = spread(4);
                end
            end else if (kind < 60) begin
                // flat top or flat bottom
                pa = $urandom_range(2);
                pb = (pa + 1 + $urandom_range(1)) % 3;
                y[pb] = y[pa];
                if ($urandom_range(3) == 0) x[pb] = x[pa];
            end else if (kind < 70) begin
                // all y or all x the same
                if ($urandom_range(1) == 0) begin
                    y[1] = y[0];
                    y[2] = y[0];
                end else begin
                    x[1] = x[0];
                    x[2] = x[0];
                end
            end else if (kind < 85) begin
                // points on or next to one line, the split tie
                dx = spread(40);
                dy = spread(40);
                k  = spread(6);
                m  = spread(6);
                x[1] = x[0] + k * dx;
                y[1] = y[0] + k * dy;
                x[2] = x[0] + m * dx;
                y[2] = y[0] + m * dy;
                if ($urandom_range(1) == 0) begin
                    x[1] += spread(1);
                    y[1] += spread(1);
                end
            end else begin
                for (int j = 0; j < 3; j++) begin
                    x[j] = pick_edge();
                    y[j] = pick_edge();
                end
            end
            send_triangle(x[0], y[0], x[1], y[1], x[2], y[2]);
        end
        steady = 1'b0;
    endtask

    initial begin
        board         = new();
        steady        = 1'b0;
        cycles        = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed corners
        send_triangle(0, 0, 0, 0, 0, 0);
        send_triangle(0, 5, 10, 5, -3, 5);
        send_triangle(7, 0, 7, 10, 7, -20);
        send_triangle(10, 0, 0, 0, 5, 20);
        send_triangle(0, 0, 10, 0, 5, 20);
        send_triangle(5, 0, 10, 20, 0, 20);
        send_triangle(5, 0, 0, 20, 10, 20);
        send_triangle(0, 0, -10, 10, 5, 30);
        send_triangle(0, 0, 20, 10, 5, 30);
        send_triangle(0, 0, 10, 10, 20, 20);
        send_triangle(CoordMax, CoordMin, CoordMin, CoordMax, CoordMax, CoordMax);
        send_triangle(CoordMin, CoordMin, CoordMax, 0, CoordMin, CoordMax);
        send_triangle(CoordMax, CoordMax, CoordMin, CoordMin, CoordMax, 0);
        send_triangle(CoordMax, CoordMin, CoordMax, CoordMax, CoordMin, 1);
        send_triangle(CoordMax, CoordMax, CoordMax, CoordMax, CoordMax, CoordMax);
        send_triangle(CoordMin, CoordMin, CoordMin, CoordMin, CoordMin, CoordMin);
        send_triangle(3, 3, 3, 3, 9, 20);
        send_triangle(3, 20, 3, 20, 9, 0);
        send_triangle(0, 30, 5, 20, -5, 10);
        send_triangle(0, 10, 4, 0, 8, 10);
        send_triangle(CoordMin, CoordMin, CoordMin, 0, CoordMin, CoordMax);
        send_triangle(32'h55555, 32'hAAAAA, 32'hAAAAA, 32'h55555, 0, 0);
        send_triangle(-1, -1, 1, 1, -1, 1);
        directed = board.triangles;

        send_random(RandomTris);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;

        while (board.owed.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("covered %0d triangles (%0d directed): %0d degenerate, %0d flat, %0d split",
                 board.triangles, directed, board.degenerate, board.flat, board.split);
        $display("checked %0d trapezoid transactions, %0d field mismatches",
                 board.checked, board.mismatches);
        if (board.mismatches == 0 && board.owed.size() == 0) begin
            $display("triangle_trapezoid_split verification clean");
        end else begin
            $display("triangle_trapezoid_split verification failed");
        end
        $finish;
    end

endmodule
